// ----- sv/assert_macros.svh -----
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define CHK_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("check failed");

// next-cycle implication, off during reset
`define CHK_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("check failed");

`endif

// ----- sv/dfmod_pkg.sv -----
package dfmod_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned QueueDepth = 2;
   localparam logic [10:0] ExpAllOnes = 11'h7ff;
   localparam logic [63:0] FracMask = 64'h000f_ffff_ffff_ffff;
   localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
   localparam logic [63:0] QuietNan = 64'h7ff8_0000_0000_0000;
   localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

   // classification of one word by the front part
   typedef enum logic [1:0] {
      CLS_DIRECT = 2'd0,
      CLS_REDUCE = 2'd1
   } cls_type;

   // word passed from the front part to the back part
   typedef struct packed {
      cls_type     cls;
      logic [63:0] direct;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } job_type;

endpackage

// ----- sv/double_fmod_unit_core.sv -----
// channel   direction  handshake         payload
// req       in         req_valid/stall   req_dividend_bits, req_divisor_bits
// rsp       out        rsp_valid/stall   rsp_remainder_bits
// special cases (nan, |x|<=|y|): result made in the front part, no reduction
// reduction: load, normalize shifts of x and of y, one shift-subtract per
// exponent step (up to 2097), last subtract, remainder normalize shifts, then pack
// reset is synchronous, active high, and empties the queue and the back part
// a stalled result holds its register; the front queue keeps taking words until full
module double_fmod_unit_core #(
   parameter int unsigned DEPTH = dfmod_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_dividend_bits,
   input  logic [63:0] req_divisor_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_remainder_bits
);

   logic job_valid, job_pop;
   dfmod_pkg::job_type job;

   dfmod_front #(.DEPTH(DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_dividend_bits,
      .req_divisor_bits, .job_valid, .job_pop, .job
   );

   dfmod_back u_back (
      .clock, .reset, .job_valid, .job_pop, .job,
      .rsp_valid, .rsp_stall, .rsp_remainder_bits
   );

endmodule

// ----- sv/dfmod_front.sv -----
module dfmod_front #(
   parameter int unsigned DEPTH = dfmod_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [63:0]         req_dividend_bits,
   input  logic [63:0]         req_divisor_bits,
   output logic                job_valid,
   input  logic                job_pop,
   output dfmod_pkg::job_type  job
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   dfmod_pkg::job_type queue_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   dfmod_pkg::job_type cls_job;
   logic [10:0] ex, ey;
   logic [63:0] xa, ya;
   logic y_nan, push;

   // classify the incoming word
   always_comb begin
      ex = req_dividend_bits[62:52];
      ey = req_divisor_bits[62:52];
      xa = {req_dividend_bits[62:0], 1'b0};
      ya = {req_divisor_bits[62:0], 1'b0};
      y_nan = (ey == dfmod_pkg::ExpAllOnes) && ((req_divisor_bits & dfmod_pkg::FracMask) != '0);
      cls_job.dividend = req_dividend_bits;
      cls_job.divisor = req_divisor_bits;
      cls_job.cls = dfmod_pkg::CLS_DIRECT;
      cls_job.direct = req_dividend_bits;
      if (ya == '0 || y_nan || ex == dfmod_pkg::ExpAllOnes) begin
         cls_job.direct = dfmod_pkg::QuietNan;
      end else if (xa == ya) begin
         cls_job.direct = req_dividend_bits & dfmod_pkg::SignBit;
      end else if (xa > ya) begin
         cls_job.cls = dfmod_pkg::CLS_REDUCE;
      end
   end

   assign req_stall = (count_ff == (PtrW+1)'(DEPTH));
   assign push = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign job = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (job_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && job_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls_job;
      end
   end

endmodule

// ----- sv/dfmod_back.sv -----
module dfmod_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_pop,
   input  dfmod_pkg::job_type job,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_remainder_bits
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_NORMX = 7'b0000010,
      ST_NORMY = 7'b0000100,
      ST_RED   = 7'b0001000,
      ST_LAST  = 7'b0010000,
      ST_RENRM = 7'b0100000,
      ST_PACK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [63:0] mx_ff, mx_in, my_ff, my_in, out_ff, out_in;
   logic signed [12:0] ex_ff, ex_in, ey_ff, ey_in;
   logic sign_ff, sign_in, out_valid_ff, out_valid_in;
   logic [63:0] diff;
   logic [12:0] sh;

   assign rsp_valid = out_valid_ff;
   assign rsp_remainder_bits = out_ff;
   assign diff = mx_ff - my_ff;
   assign sh = 13'sd1 - ex_ff;

   // load a job, then one shift-subtract or normalize step per cycle, then pack the result
   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      sign_in = sign_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      job_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && !out_valid_in) begin
               job_pop = 1'b1;
               if (job.cls == dfmod_pkg::CLS_DIRECT) begin
                  out_in = job.direct;
                  out_valid_in = 1'b1;
               end else begin
                  sign_in = job.dividend[63];
                  ex_in = 13'(job.dividend[62:52]);
                  ey_in = 13'(job.divisor[62:52]);
                  mx_in = (job.dividend & dfmod_pkg::FracMask)
                     | ((job.dividend[62:52] != '0) ? dfmod_pkg::HiddenBit : '0);
                  my_in = (job.divisor & dfmod_pkg::FracMask)
                     | ((job.divisor[62:52] != '0) ? dfmod_pkg::HiddenBit : '0);
                  if (job.dividend[62:52] == '0) begin
                     ex_in = 13'sd1;
                  end
                  if (job.divisor[62:52] == '0) begin
                     ey_in = 13'sd1;
                  end
                  state_in = ST_NORMX;
               end
            end
         end
         ST_NORMX: begin
            if (mx_ff[52]) begin
               state_in = ST_NORMY;
            end else begin
               mx_in = {mx_ff[62:0], 1'b0};
               ex_in = ex_ff - 13'sd1;
            end
         end
         ST_NORMY: begin
            if (my_ff[52]) begin
               state_in = (ex_ff > ey_ff) ? ST_RED : ST_LAST;
            end else begin
               my_in = {my_ff[62:0], 1'b0};
               ey_in = ey_ff - 13'sd1;
            end
         end
         ST_RED: begin
            if (!diff[63] && diff == '0) begin
               out_in = {sign_ff, 63'd0};
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mx_in = diff[63] ? {mx_ff[62:0], 1'b0} : {diff[62:0], 1'b0};
               ex_in = ex_ff - 13'sd1;
               if (ex_ff - 13'sd1 <= ey_ff) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            if (!diff[63] && diff == '0) begin
               out_in = {sign_ff, 63'd0};
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               if (!diff[63]) begin
                  mx_in = diff;
               end
               state_in = ST_RENRM;
            end
         end
         ST_RENRM: begin
            if (mx_ff[52]) begin
               state_in = ST_PACK;
            end else begin
               mx_in = {mx_ff[62:0], 1'b0};
               ex_in = ex_ff - 13'sd1;
            end
         end
         ST_PACK: begin
            if (!out_valid_in) begin
               if (ex_ff > 13'sd0) begin
                  out_in = {sign_ff, 63'((mx_ff - dfmod_pkg::HiddenBit)
                     | {ex_ff[10:0], 52'd0})};
               end else begin
                  out_in = {sign_ff, 63'((sh < 13'd64) ? (mx_ff >> sh[5:0]) : '0)};
               end
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in;
      my_ff <= my_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      sign_ff <= sign_in;
      out_ff <= out_in;
   end

endmodule

// ----- sv/dfmod_checker.sv -----
`include "assert_macros.svh"

module dfmod_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_remainder_bits
);

   `CHK_NEXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CHK_NEXT(rsp_data_a, clock, reset, rsp_valid && rsp_stall, $stable(rsp_remainder_bits))
   `CHK_NEXT(reset_clear_a, clock, 1'b0, reset, !rsp_valid)
   `CHK_IMPLY(ctrl_known_a, clock, reset, 1'b1, !$isunknown({req_stall, rsp_valid}))

endmodule

bind double_fmod_unit_core dfmod_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_remainder_bits
);

// ----- sim/tb_double_fmod_unit_core.sv -----
`timescale 1ns / 100ps

module tb_double_fmod_unit_core;

   localparam int unsigned CycleLimit = 4_000_000;
   localparam int unsigned HoldCycles = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_dividend_bits;
   logic [63:0] req_divisor_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_remainder_bits;

   logic [63:0] remainder_q[$];
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned words_sent;
   int unsigned words_checked;
   bit          idle_on;
   bit          hold_request;
   int unsigned hold_left;

   double_fmod_unit_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dividend_bits  (req_dividend_bits),
      .req_divisor_bits   (req_divisor_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_remainder_bits (rsp_remainder_bits)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // normalize a significand, e is the biased exponent field
   function automatic logic [63:0] normalize_sig(input logic [63:0] bits, inout int e);
      logic [63:0] probe;
      int k;
      if (e == 0) begin
         probe = bits << 12;
         k = 0;
         while (probe != 0 && !probe[63]) begin
            k--;
            probe = probe << 1;
         end
         e = k;
         return bits << (1 - k);
      end
      return (bits & dfmod_pkg::FracMask) | dfmod_pkg::HiddenBit;
   endfunction

   // exact binary64 remainder with the sign of x
   function automatic logic [63:0] fmod_remainder(input logic [63:0] xb, input logic [63:0] yb);
      int ex, ey, sh;
      logic [63:0] sgn, xa, ya, mx, my, d;
      bit y_nan;
      ex = int'(xb[62:52]);
      ey = int'(yb[62:52]);
      sgn = xb & dfmod_pkg::SignBit;
      xa = xb << 1;
      ya = yb << 1;
      y_nan = (yb[62:52] == dfmod_pkg::ExpAllOnes) && ((yb & dfmod_pkg::FracMask) != 0);
      if (ya == 0 || y_nan || xb[62:52] == dfmod_pkg::ExpAllOnes) return dfmod_pkg::QuietNan;
      if (xa <= ya) return (xa == ya) ? sgn : xb;
      mx = normalize_sig(xb, ex);
      my = normalize_sig(yb, ey);
      // restoring shift-subtract over the exponent difference
      while (ex > ey) begin
         d = mx - my;
         if (!d[63]) begin
            if (d == 0) return sgn;
            mx = d;
         end
         mx = mx << 1;
         ex--;
      end
      d = mx - my;
      if (!d[63]) begin
         if (d == 0) return sgn;
         mx = d;
      end
      // renormalize and repack
      while (mx != 0 && mx[63:52] == 0) begin
         mx = mx << 1;
         ex--;
      end
      if (ex > 0) begin
         mx = (mx - dfmod_pkg::HiddenBit) | (64'(ex) << 52);
      end else begin
         sh = 1 - ex;
         mx = (sh < 64) ? (mx >> sh) : 64'd0;
      end
      return mx | sgn;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side stall, with a long hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 25);
      end
   end

   // compare each result word with the oldest expected remainder
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (remainder_q.size() == 0) begin
            $error("unexpected result word %h", rsp_remainder_bits);
            fail_count++;
         end else begin
            want = remainder_q.pop_front();
            words_checked++;
            if (rsp_remainder_bits !== want) begin
               $error("remainder_bits: expected %h, actual %h", want, rsp_remainder_bits);
               fail_count++;
            end
         end
      end
   end

   // offer one word and wait until it is taken
   task automatic send_word(input logic [63:0] x, input logic [63:0] y);
      if (idle_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dividend_bits <= x;
      req_divisor_bits <= y;
      do @(posedge clock); while (req_stall);
      remainder_q.push_back(fmod_remainder(x, y));
      words_sent++;
   endtask

   task automatic test_directed();
      send_word(64'h4018_0000_0000_0000, 64'h4008_0000_0000_0000); // 6 mod 3, exact
      send_word(64'hc01c_0000_0000_0000, 64'h4008_0000_0000_0000); // -7 mod 3
      send_word(64'h3ff0_0000_0000_0000, 64'h3fb9_9999_9999_999a); // 1 mod 0.1
      send_word(64'h0000_0000_0000_0000, 64'h3ff0_0000_0000_0000); // zero dividend
      send_word(64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000); // -0 mod inf
      send_word(64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000); // divide by zero
      send_word(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000); // divide by -zero
      send_word(64'h7ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000); // infinite dividend
      send_word(64'hfff8_0000_0000_0001, 64'h3ff0_0000_0000_0000); // nan dividend
      send_word(64'h3ff0_0000_0000_0000, 64'h7ff0_0000_0000_0001); // nan divisor
      send_word(64'hc000_0000_0000_0000, 64'hfff0_0000_0000_0000); // finite mod -inf
      send_word(64'hbff0_0000_0000_0000, 64'h3ff0_0000_0000_0000); // equal magnitudes
      send_word(64'h3ff0_0000_0000_0000, 64'h4000_0000_0000_0000); // smaller dividend
      send_word(64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000); // subnormal remainder
      send_word(64'h000f_ffff_ffff_ffff, 64'h0000_0000_0000_0003); // subnormal both
      send_word(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001); // min subnormal equal
      send_word(64'h7fef_ffff_ffff_ffff, 64'h0000_0000_0000_0001); // widest reduction
      send_word(64'hffef_ffff_ffff_ffff, 64'h000f_ffff_ffff_ffff); // max mod max subnormal
      send_word(64'h7fef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_fffe); // near-equal large
      send_word(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff); // all ones
   endtask

   // random operands, mostly near exponents with random fractions
   task automatic test_random(input int n);
      logic [63:0] x, y;
      int e, f;
      repeat (n) begin
         x = {$urandom, $urandom};
         y = {$urandom, $urandom};
         case ($urandom_range(9))
            0: ; // raw patterns, wide exponent spread
            1: begin
               x[62:52] = 11'($urandom_range(2));
               y[62:52] = 11'($urandom_range(1));
            end
            2: begin
               if ($urandom_range(1)) x[62:52] = dfmod_pkg::ExpAllOnes;
               else y[62:52] = dfmod_pkg::ExpAllOnes;
               if ($urandom_range(1)) y[51:0] = '0;
               if ($urandom_range(3) == 0) y[62:0] = '0;
               if ($urandom_range(3) == 0) x[62:0] = '0;
            end
            default: begin
               e = $urandom_range(1, 2046);
               f = e - $urandom_range(0, 60);
               if ($urandom_range(7) == 0) f = e + $urandom_range(0, 2);
               if (f < 0) f = 0;
               if (f > 2046) f = 2046;
               x[62:52] = 11'(e);
               y[62:52] = 11'(f);
            end
         endcase
         send_word(x, y);
      end
   endtask

   // hold the result side while words keep coming
   task automatic test_output_hold();
      hold_request = 1'b1;
      test_random(20);
   endtask

   // sender pauses until every expected word is back
   task automatic test_drain_pause();
      req_valid <= 1'b0;
      wait (remainder_q.size() == 0);
      @(posedge clock);
      test_random(10);
   endtask

   // no idling on either side
   task automatic test_full_rate();
      idle_on = 1'b0;
      test_random(40);
      idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_dividend_bits = '0;
      req_divisor_bits = '0;
      rsp_stall = 1'b0;
      cycle_count = 0;
      fail_count = 0;
      words_sent = 0;
      words_checked = 0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      hold_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(180);
      test_output_hold();
      test_drain_pause();
      test_full_rate();
      test_random(20);

      req_valid <= 1'b0;
      wait (remainder_q.size() == 0);
      repeat (50) @(posedge clock);
      $display("sent %0d words, checked %0d remainders", words_sent, words_checked);
      $display("covered nan and zero cases, subnormals, deep reductions, output hold");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
